// ===== hdl/mhhc_pkg.sv =====
// ---------------------------------------------------------------------------
// mhhc_pkg
// Shared types, constants and match tables for the mail header hop counter.
// ---------------------------------------------------------------------------
package mhhc_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_HOPS     = 2'd2
  } status_t;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic {
    CFG_MAX_DATA_BYTES = 1'b0,
    CFG_MAX_HOPS       = 1'b1
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned HOP_W      = 16;

  localparam logic [HOP_W-1:0] HOP_DEFAULT      = 16'd100;
  localparam logic [3:0]       LINE_CAP         = 4'd13;
  localparam logic [3:0]       REC_LAST         = 4'd8;
  localparam logic [3:0]       DLV_LAST         = 4'd12;
  localparam logic [7:0]       LINE_FEED        = 8'h0A;

  // Case-insensitive compare against "received:" at line position k.
  function automatic logic rec_char_ok(input logic [3:0] k, input logic [7:0] ch);
    logic ok;
    unique case (k)
      4'd0:    ok = (ch == "r") || (ch == "R");
      4'd1:    ok = (ch == "e") || (ch == "E");
      4'd2:    ok = (ch == "c") || (ch == "C");
      4'd3:    ok = (ch == "e") || (ch == "E");
      4'd4:    ok = (ch == "i") || (ch == "I");
      4'd5:    ok = (ch == "v") || (ch == "V");
      4'd6:    ok = (ch == "e") || (ch == "E");
      4'd7:    ok = (ch == "d") || (ch == "D");
      4'd8:    ok = (ch == ":");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Case-insensitive compare against "delivered-to:" at line position k.
  function automatic logic dlv_char_ok(input logic [3:0] k, input logic [7:0] ch);
    logic ok;
    unique case (k)
      4'd0:    ok = (ch == "d") || (ch == "D");
      4'd1:    ok = (ch == "e") || (ch == "E");
      4'd2:    ok = (ch == "l") || (ch == "L");
      4'd3:    ok = (ch == "i") || (ch == "I");
      4'd4:    ok = (ch == "v") || (ch == "V");
      4'd5:    ok = (ch == "e") || (ch == "E");
      4'd6:    ok = (ch == "r") || (ch == "R");
      4'd7:    ok = (ch == "e") || (ch == "E");
      4'd8:    ok = (ch == "d") || (ch == "D");
      4'd9:    ok = (ch == "-");
      4'd10:   ok = (ch == "t") || (ch == "T");
      4'd11:   ok = (ch == "o") || (ch == "O");
      4'd12:   ok = (ch == ":");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== hdl/mhhc_in_if.sv =====
// ---------------------------------------------------------------------------
// mhhc_in_if
// Request channel: one message byte or a start-of-message event.
// ---------------------------------------------------------------------------
interface mhhc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// ===== hdl/mhhc_out_if.sv =====
// ---------------------------------------------------------------------------
// mhhc_out_if
// Result channel: status and header flag for each request.
// ---------------------------------------------------------------------------
interface mhhc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       header_open;

  modport source (output valid, output status, output header_open, input ready);
  modport sink   (input valid, input status, input header_open, output ready);
endinterface

// ===== hdl/mail_header_hop_counter_unit.sv =====
// ---------------------------------------------------------------------------
// mail_header_hop_counter_unit
// Counts message bytes and trace headers (received:, delivered-to:) in the
// header section and flags oversize messages and hop loops.
// ---------------------------------------------------------------------------
//
//  channel   dir   handshake         payload
//  in_ch     in    valid/ready       op, data_byte
//  out_ch    out   valid/ready       status, header_open
//  cfg_*     in    cfg_we            cfg_index, cfg_data
//
//  One request per cycle while the sink keeps up; its result is in the
//  output register the cycle after acceptance. Scan state loads on accept.
//  in_ch.ready is high whenever the output register is empty or being
//  drained, so a stalled sink holds one result and stops intake.
//  rst_n (synchronous) clears the scan state, sets max_data_bytes to 0 and
//  max_hops to 100.
//
module mail_header_hop_counter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mhhc_in_if.sink                              in_ch,
  mhhc_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  mhhc_pkg::cfg_idx_t                   cfg_index,
  input  logic [mhhc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [31:0]                  max_data_bytes_r;
  logic [mhhc_pkg::HOP_W-1:0]   max_hops_r;

  logic [31:0]                  byte_total_r,    byte_total_nxt;
  logic [mhhc_pkg::HOP_W-1:0]   rec_total_r,     rec_total_nxt;
  logic [mhhc_pkg::HOP_W-1:0]   dlv_total_r,     dlv_total_nxt;
  logic                         header_r,        header_nxt;
  logic [3:0]                   line_off_r,      line_off_nxt;
  logic                         rec_cand_r,      rec_cand_nxt;
  logic                         dlv_cand_r,      dlv_cand_nxt;

  logic                         out_valid_r;
  mhhc_pkg::status_t            out_status_r,    status_nxt;
  logic                         out_header_r;

  logic                         in_acc;
  logic [31:0]                  byte_inc;
  logic [mhhc_pkg::HOP_W-1:0]   rec_inc;
  logic [mhhc_pkg::HOP_W-1:0]   dlv_inc;
  logic [mhhc_pkg::HOP_W-1:0]   hop_lim;
  logic                         size_over;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.header_open = out_header_r;

  assign byte_inc  = (byte_total_r == '1) ? byte_total_r : byte_total_r + 32'd1;
  assign rec_inc   = (rec_total_r == '1) ? rec_total_r : rec_total_r + 16'd1;
  assign dlv_inc   = (dlv_total_r == '1) ? dlv_total_r : dlv_total_r + 16'd1;
  assign hop_lim   = (max_hops_r == '0) ? mhhc_pkg::HOP_DEFAULT : max_hops_r;
  assign size_over = (max_data_bytes_r != '0) && (byte_inc > max_data_bytes_r);

  always_comb begin
    byte_total_nxt = byte_total_r;
    rec_total_nxt  = rec_total_r;
    dlv_total_nxt  = dlv_total_r;
    header_nxt     = header_r;
    line_off_nxt   = line_off_r;
    rec_cand_nxt   = rec_cand_r;
    dlv_cand_nxt   = dlv_cand_r;
    status_nxt     = mhhc_pkg::STATUS_OK;

    if (in_ch.op == mhhc_pkg::OP_START) begin
      byte_total_nxt = '0;
      rec_total_nxt  = '0;
      dlv_total_nxt  = '0;
      header_nxt     = 1'b1;
      line_off_nxt   = '0;
      rec_cand_nxt   = 1'b1;
      dlv_cand_nxt   = 1'b1;
    end else begin
      byte_total_nxt = byte_inc;
      // past the header only the byte count advances
      if (size_over) begin
        status_nxt = mhhc_pkg::STATUS_TOO_LONG;
      end else if (header_r) begin
        if (in_ch.data_byte == mhhc_pkg::LINE_FEED) begin
          // an empty line closes the header
          if (line_off_r == '0) header_nxt = 1'b0;
          line_off_nxt = '0;
          rec_cand_nxt = header_nxt;
          dlv_cand_nxt = header_nxt;
        end else if (line_off_r < mhhc_pkg::LINE_CAP) begin
          if (rec_cand_r) begin
            if (!mhhc_pkg::rec_char_ok(line_off_r, in_ch.data_byte)) begin
              rec_cand_nxt = 1'b0;
            end else if (line_off_r == mhhc_pkg::REC_LAST) begin
              rec_cand_nxt  = 1'b0;
              dlv_cand_nxt  = 1'b0;
              rec_total_nxt = rec_inc;
              if (rec_inc > hop_lim) status_nxt = mhhc_pkg::STATUS_HOPS;
            end
          end
          // a completed received: match drops the other candidate too
          if (dlv_cand_nxt) begin
            if (!mhhc_pkg::dlv_char_ok(line_off_r, in_ch.data_byte)) begin
              dlv_cand_nxt = 1'b0;
            end else if (line_off_r == mhhc_pkg::DLV_LAST) begin
              rec_cand_nxt  = 1'b0;
              dlv_cand_nxt  = 1'b0;
              dlv_total_nxt = dlv_inc;
              if (dlv_inc > hop_lim) status_nxt = mhhc_pkg::STATUS_HOPS;
            end
          end
          line_off_nxt = line_off_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_data_bytes_r <= '0;
      max_hops_r       <= mhhc_pkg::HOP_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mhhc_pkg::CFG_MAX_DATA_BYTES: max_data_bytes_r <= cfg_data;
        mhhc_pkg::CFG_MAX_HOPS:       max_hops_r <= cfg_data[mhhc_pkg::HOP_W-1:0];
        default:                      max_hops_r <= max_hops_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_total_r <= '0;
      rec_total_r  <= '0;
      dlv_total_r  <= '0;
      header_r     <= 1'b1;
      line_off_r   <= '0;
      rec_cand_r   <= 1'b1;
      dlv_cand_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        byte_total_r <= byte_total_nxt;
        rec_total_r  <= rec_total_nxt;
        dlv_total_r  <= dlv_total_nxt;
        header_r     <= header_nxt;
        line_off_r   <= line_off_nxt;
        rec_cand_r   <= rec_cand_nxt;
        dlv_cand_r   <= dlv_cand_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r <= status_nxt;
      out_header_r <= header_nxt;
    end
  end

endmodule

// ===== hdl/mhhc_checker.sv =====
// ---------------------------------------------------------------------------
// mhhc_checker
// Port-level checks for the mail header hop counter, bound to the top level.
// ---------------------------------------------------------------------------
module mhhc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_header_open
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_header_open))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("intake blocked with empty output register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> out_valid
      && out_status == mhhc_pkg::STATUS_OK && out_header_open)
    else $error("start of message result wrong");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind mail_header_hop_counter_unit mhhc_checker u_mhhc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_op           (in_ch.op),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_header_open (out_ch.header_open)
);

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for mail_header_hop_counter_unit. A short directed
// message is followed by randomly built mail messages (trace headers in mixed
// case, near misses, long lines, binary noise, bodies) under several byte and
// hop limits. Each result is compared against an in-bench model of the scan.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_REQUESTS = 170;

  // Mirrors the header scan and holds the verdicts still owed by the block.
  class hop_count_scoreboard;
    typedef struct packed {
      mhhc_pkg::status_t status;
      logic              header_open;
    } verdict_t;

    logic [31:0] byte_limit;
    logic [15:0] hop_limit;
    logic [31:0] bytes_seen;
    logic [15:0] received_hops;
    logic [15:0] delivered_hops;
    logic [3:0]  line_pos;
    bit          hdr_open;
    bit          maybe_received;
    bit          maybe_delivered;
    verdict_t    expected_verdicts[$];
    int          mismatches;
    int          checked;
    int          hop_flags;
    int          long_flags;

    function new();
      byte_limit = '0;
      hop_limit  = mhhc_pkg::HOP_DEFAULT;
      mismatches = 0;
      checked    = 0;
      hop_flags  = 0;
      long_flags = 0;
      clear_message();
    endfunction

    function void clear_message();
      bytes_seen      = '0;
      received_hops   = '0;
      delivered_hops  = '0;
      line_pos        = '0;
      hdr_open        = 1'b1;
      maybe_received  = 1'b1;
      maybe_delivered = 1'b1;
    endfunction

    function void set_limits(logic [31:0] data_limit, logic [15:0] hops);
      byte_limit = data_limit;
      hop_limit  = hops;
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function bit tag_hit(string tag, logic [3:0] k, logic [7:0] c);
      return (int'(k) < tag.len()) && (fold(c) == tag[k]);
    endfunction

    function bit over_limit(logic [15:0] count);
      logic [15:0] lim;
      lim = (hop_limit == 0) ? mhhc_pkg::HOP_DEFAULT : hop_limit;
      return count > lim;
    endfunction

    function void predict_request(mhhc_pkg::op_t op, logic [7:0] c);
      verdict_t    v;
      logic [3:0]  k;
      v.status = mhhc_pkg::STATUS_OK;
      if (op == mhhc_pkg::OP_START) begin
        clear_message();
      end else begin
        if (bytes_seen != '1) bytes_seen++;
        if (byte_limit != 0 && bytes_seen > byte_limit) begin
          v.status = mhhc_pkg::STATUS_TOO_LONG;
        end else if (hdr_open) begin
          if (c == mhhc_pkg::LINE_FEED) begin
            // an empty line ends the header
            if (line_pos == 0) hdr_open = 1'b0;
            line_pos        = '0;
            maybe_received  = hdr_open;
            maybe_delivered = hdr_open;
          end else if (line_pos < mhhc_pkg::LINE_CAP) begin
            k = line_pos;
            if (maybe_received) begin
              if (k > mhhc_pkg::REC_LAST || !tag_hit("received:", k, c)) begin
                maybe_received = 1'b0;
              end else if (k == mhhc_pkg::REC_LAST) begin
                maybe_received  = 1'b0;
                maybe_delivered = 1'b0;
                if (received_hops != '1) received_hops++;
                if (over_limit(received_hops)) v.status = mhhc_pkg::STATUS_HOPS;
              end
            end
            if (maybe_delivered) begin
              if (!tag_hit("delivered-to:", k, c)) begin
                maybe_delivered = 1'b0;
              end else if (k == mhhc_pkg::DLV_LAST) begin
                maybe_received  = 1'b0;
                maybe_delivered = 1'b0;
                if (delivered_hops != '1) delivered_hops++;
                if (over_limit(delivered_hops)) v.status = mhhc_pkg::STATUS_HOPS;
              end
            end
            line_pos = k + 4'd1;
          end
        end
      end
      v.header_open = hdr_open;
      if (v.status == mhhc_pkg::STATUS_HOPS) hop_flags++;
      if (v.status == mhhc_pkg::STATUS_TOO_LONG) long_flags++;
      expected_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [1:0] status, logic header_open);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending: status %0d header_open %0b",
                 $time, status, header_open);
        return;
      end
      v = expected_verdicts.pop_front();
      checked++;
      if (status !== v.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, v.status, status);
      end
      if (header_open !== v.header_open) begin
        mismatches++;
        $display("%0t: header_open mismatch: expected %0b actual %0b",
                 $time, v.header_open, header_open);
      end
    endfunction

    function int outstanding();
      return expected_verdicts.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  mhhc_pkg::cfg_idx_t cfg_index;
  logic [31:0]        cfg_data;

  mhhc_in_if  in_ch();
  mhhc_out_if out_ch();

  mail_header_hop_counter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hop_count_scoreboard book;
  bit          gaps_on;
  int          long_stall_cycles;
  int          requests_sent;
  int          cycle_count;
  logic [31:0] data_limits [PHASE_COUNT] = '{32'd0, 32'd0, 32'd60, 32'd0,
                                           32'hFFFF_FFFF, 32'd1};
  logic [15:0] hop_limits  [PHASE_COUNT] = '{16'd100, 16'd1, 16'd2, 16'd0,
                                           16'hFFFF, 16'd3};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_gap();
    return gaps_on ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic logic [7:0] dress(logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  // Call on a clock edge; returns on the edge where the request is taken.
  task automatic send_request(mhhc_pkg::op_t op, logic [7:0] c);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= c;
    do @(posedge clk); while (!in_ch.ready);
    book.predict_request(op, c);
    requests_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(mhhc_pkg::OP_DATA, s[i]);
  endtask

  // Send the first upto chars of tag in random case, the one at flaw_at (if any) replaced.
  task automatic send_tag(string tag, int upto, int flaw_at);
    logic [7:0] c;
    for (int i = 0; i < upto; i++) begin
      c = (i == flaw_at) ? 8'($urandom_range(0, 255)) : dress(tag[i]);
      send_request(mhhc_pkg::OP_DATA, c);
    end
  endtask

  task automatic send_header_line();
    string tag;
    int    pick;
    pick = $urandom_range(0, 9);
    tag  = $urandom_range(0, 1) ? "received:" : "delivered-to:";
    case (pick)
      0, 1, 2: send_tag("received:", 9, -1);
      3, 4:    send_tag("delivered-to:", 13, -1);
      5:       send_tag(tag, tag.len(), $urandom_range(0, tag.len() - 1));
      6:       repeat ($urandom_range(14, 20))
                 send_request(mhhc_pkg::OP_DATA, 8'($urandom_range(97, 122)));
      7:       repeat ($urandom_range(0, 10))
                 send_request(mhhc_pkg::OP_DATA, 8'($urandom_range(0, 255)));
      8:       send_tag(tag, $urandom_range(1, tag.len() - 1), -1);
      default: begin
        send_request(mhhc_pkg::OP_DATA, " ");
        send_tag(tag, tag.len(), -1);
      end
    endcase
    repeat ($urandom_range(0, 12))
      send_request(mhhc_pkg::OP_DATA, 8'($urandom_range(32, 126)));
    send_request(mhhc_pkg::OP_DATA, mhhc_pkg::LINE_FEED);
  endtask

  task automatic send_message();
    if ($urandom_range(0, 9) != 0)
      send_request(mhhc_pkg::OP_START, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 8)) send_header_line();
    if ($urandom_range(0, 9) != 0) send_request(mhhc_pkg::OP_DATA, mhhc_pkg::LINE_FEED);
    repeat ($urandom_range(0, 24)) begin
      if ($urandom_range(0, 15) == 0) send_tag("received:", 9, -1);
      else send_request(mhhc_pkg::OP_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  // Drop valid and wait until every result is back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(logic [31:0] data_limit, logic [15:0] hops);
    cfg_we    <= 1'b1;
    cfg_index <= mhhc_pkg::CFG_MAX_DATA_BYTES;
    cfg_data  <= data_limit;
    @(posedge clk);
    cfg_index <= mhhc_pkg::CFG_MAX_HOPS;
    cfg_data  <= {16'($urandom_range(0, 65535)), hops};
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_limits(data_limit, hops);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_verdict(out_ch.status, out_ch.header_open);
  end

  // Result side: random stalls, plus one long hold when asked.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_gap();
      if (long_stall_cycles > 0) begin
        gap = long_stall_cycles;
        long_stall_cycles = 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mail_header_hop_counter_unit regression: fail");
    $finish;
  end

  initial begin
    int phase_end;
    book              = new();
    gaps_on           = 1'b0;
    long_stall_cycles = 0;
    requests_sent     = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= mhhc_pkg::CFG_MAX_DATA_BYTES;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= mhhc_pkg::OP_DATA;
    in_ch.data_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: two trace headers against a hop limit of one, byte extremes,
    // header close, then the byte limit.
    write_limits(32'd24, 16'd1);
    send_request(mhhc_pkg::OP_START, 8'hFF);
    send_text("rEcEiVeD:");
    send_request(mhhc_pkg::OP_DATA, mhhc_pkg::LINE_FEED);
    send_text("RECEIVED:");
    send_request(mhhc_pkg::OP_DATA, 8'h00);
    send_request(mhhc_pkg::OP_DATA, 8'hFF);
    send_request(mhhc_pkg::OP_DATA, mhhc_pkg::LINE_FEED);
    send_request(mhhc_pkg::OP_DATA, mhhc_pkg::LINE_FEED);
    send_text("ab");

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      write_limits(data_limits[p], hop_limits[p]);
      if (p == 2) long_stall_cycles = 400;
      phase_end = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        send_message();
      end
    end
    drain_results();

    $display("Scanned %0d requests under %0d limit settings, one with a long output hold.",
             requests_sent, PHASE_COUNT + 1);
    $display("Checked %0d results; %0d hop-limit and %0d size-limit flags were expected.",
             book.checked, book.hop_flags, book.long_flags);
    if (book.mismatches == 0 && book.outstanding() == 0)
      $display("mail_header_hop_counter_unit regression: pass");
    else
      $display("mail_header_hop_counter_unit regression: fail");
    $finish;
  end

endmodule
